// ----- design/clcd_pkg.sv -----
// ----------------------------------------------------------------------------
// clcd_pkg: shared types and constants of the character LCD bus controller
// Phase and operation codes, configuration and item structures, and the
// power-on initialization step decoder.
// ----------------------------------------------------------------------------
package clcd_pkg;

  localparam int DELAY_WIDTH_DEF = 16;

  localparam logic [7:0] CMD_CLEAR       = 8'h01;
  localparam logic [7:0] CMD_HOME        = 8'h02;
  localparam logic [3:0] INIT_NIBBLE     = 4'h3;
  localparam logic [3:0] FOUR_BIT_NIBBLE = 4'h2;

  localparam logic [7:0]  PHASE_TICKS_RST      = 8'd1;
  localparam logic [15:0] POWER_ON_WAIT_RST    = 16'd15000;
  localparam logic [15:0] FIRST_INIT_WAIT_RST  = 16'd5000;
  localparam logic [15:0] SECOND_INIT_WAIT_RST = 16'd200;
  localparam logic [7:0]  FUNCTION_SET_RST     = 8'h28;
  localparam logic [7:0]  DISPLAY_CMD_RST      = 8'd15;

  typedef enum logic [4:0] {
    PH_IDLE  = 5'd0,
    PH_WAIT  = 5'd1,
    PH_POLL0 = 5'd2,
    PH_POLL1,
    PH_POLL2,
    PH_POLL3,
    PH_POLL4,
    PH_WR0,
    PH_WR1,
    PH_WR2,
    PH_WR3,
    PH_WR4,
    PH_WR5,
    PH_RD0,
    PH_RD1,
    PH_RD2,
    PH_RD3,
    PH_RD4,
    PH_RD5,
    PH_NB0,
    PH_NB1,
    PH_NB2
  } phase_t;

  typedef enum logic [2:0] {
    OP_TICK     = 3'd0,
    OP_WR_INSTR = 3'd1,
    OP_WR_DATA  = 3'd2,
    OP_RD_BUSY  = 3'd3,
    OP_RD_DATA  = 3'd4,
    OP_INIT     = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    CFG_PHASE_TICKS      = 3'd0,
    CFG_POWER_ON_WAIT    = 3'd1,
    CFG_FIRST_INIT_WAIT  = 3'd2,
    CFG_SECOND_INIT_WAIT = 3'd3,
    CFG_FUNCTION_SET_CMD = 3'd4,
    CFG_DISPLAY_CMD      = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0]  phase_ticks;
    logic [15:0] power_on_wait;
    logic [15:0] first_init_wait;
    logic [15:0] second_init_wait;
    logic [7:0]  function_set_cmd;
    logic [7:0]  display_cmd;
  } cfg_t;

  typedef struct packed {
    logic [2:0] operation;
    logic [7:0] command_byte;
    logic [3:0] bus_in;
  } item_t;

  typedef struct packed {
    logic       pin_rs;
    logic       pin_rw;
    logic       pin_enable;
    logic [3:0] pin_data;
    logic       data_drive;
    logic       ready_res;
    logic       read_valid;
    logic [7:0] read_byte;
    logic       rejected;
  } result_t;

  typedef struct packed {
    logic idle;
    logic delay_zero;
  } status_t;

  // Outcome of one initialization step: the phase to enter, its raw length,
  // the advanced step and the holding registers it loads.
  typedef struct packed {
    phase_t      ph;
    logic [15:0] ticks;
    logic [3:0]  step;
    logic        hold_we;
    logic [3:0]  hold;
    logic        pend_we;
    logic [7:0]  pend;
  } igo_t;

  // A step whose wait is zero falls through to the nibble that follows it.
  function automatic igo_t init_go(input logic [3:0] step, input cfg_t cfg);
    igo_t r;
    r.ph      = PH_IDLE;
    r.ticks   = 16'd0;
    r.step    = step;
    r.hold_we = 1'b0;
    r.hold    = INIT_NIBBLE;
    r.pend_we = 1'b0;
    r.pend    = 8'd0;
    unique case (step)
      4'd0, 4'd2, 4'd4: begin
        r.ticks = (step == 4'd0) ? cfg.power_on_wait :
                  (step == 4'd2) ? cfg.first_init_wait : cfg.second_init_wait;
        if (r.ticks != 16'd0) begin
          r.ph   = PH_WAIT;
          r.step = step + 4'd1;
        end else begin
          r.ph      = PH_NB0;
          r.ticks   = {8'd0, cfg.phase_ticks};
          r.hold_we = 1'b1;
          r.step    = step + 4'd2;
        end
      end
      4'd1, 4'd3, 4'd5, 4'd6: begin
        r.ph      = PH_NB0;
        r.ticks   = {8'd0, cfg.phase_ticks};
        r.hold_we = 1'b1;
        r.hold    = (step == 4'd6) ? FOUR_BIT_NIBBLE : INIT_NIBBLE;
        r.step    = step + 4'd1;
      end
      4'd7, 4'd8, 4'd9, 4'd10: begin
        r.ph      = PH_POLL0;
        r.ticks   = {8'd0, cfg.phase_ticks};
        r.pend_we = 1'b1;
        r.pend    = (step == 4'd7) ? cfg.function_set_cmd :
                    (step == 4'd8) ? CMD_CLEAR :
                    (step == 4'd9) ? CMD_HOME : cfg.display_cmd;
        r.step    = step + 4'd1;
      end
      default: begin
        r.ph = PH_IDLE;
      end
    endcase
    return r;
  endfunction

endpackage

// ----- design/clcd_if.sv -----
// ----------------------------------------------------------------------------
// clcd_if: valid/ready channels of the character LCD bus controller
// One interface for the tick items coming in and one for the pin results.
// ----------------------------------------------------------------------------
interface clcd_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] operation;
  logic [7:0] command_byte;
  logic [3:0] bus_in;

  modport source (output valid, output operation, output command_byte, output bus_in,
                  input ready);
  modport sink (input valid, input operation, input command_byte, input bus_in,
                output ready);
endinterface

interface clcd_out_if;
  logic       valid;
  logic       ready;
  logic       pin_rs;
  logic       pin_rw;
  logic       pin_enable;
  logic [3:0] pin_data;
  logic       data_drive;
  logic       ready_res;
  logic       read_valid;
  logic [7:0] read_byte;
  logic       rejected;

  modport source (output valid, output pin_rs, output pin_rw, output pin_enable,
                  output pin_data, output data_drive, output ready_res,
                  output read_valid, output read_byte, output rejected,
                  input ready);
  modport sink (input valid, input pin_rs, input pin_rw, input pin_enable,
                input pin_data, input data_drive, input ready_res,
                input read_valid, input read_byte, input rejected,
                output ready);
endinterface

// ----- design/char_lcd_4bit_bus_controller.sv -----
// ----------------------------------------------------------------------------
// char_lcd_4bit_bus_controller: character LCD controller for a 4-bit bus
// Each input transfer is one time tick carrying an optional command and the
// nibble sampled from the display; each tick gives one pin result transfer.
//
// in_chan carries operation, command_byte and bus_in; out_chan carries the
// pin levels, ready_res, read_valid, read_byte and rejected for that tick.
// The cfg_ port writes the timing and init command registers, one register
// per cycle at cfg_index; the user must write only while no tick is in
// flight, as the block itself does not enforce it. A tick taken on in_chan
// lands in the input register, is worked out into the result register,
// and is offered on out_chan from then on. Throughput: one tick per cycle
// while the receiver does not stall; the sequencer step is worked out
// between the input register and the result register, and both refill
// every cycle. When the receiver stalls, the result register holds, the
// sequencer does not advance, and in_chan deasserts ready as soon as the
// input register holds a tick. Reset returns the sequencer to idle and
// the registers to their power-up defaults; no clearing pass follows.
// ----------------------------------------------------------------------------
module char_lcd_4bit_bus_controller
  import clcd_pkg::*;
#(
  parameter int DELAY_WIDTH = DELAY_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  clcd_in_if.sink     in_chan,
  clcd_out_if.source  out_chan,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t    cfg;
  item_t   item;
  logic    in_v;
  logic    can_load;
  logic    adv;
  result_t result;
  status_t st;

  assign adv = in_v && can_load;

  clcd_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  clcd_in_reg u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .adv        (adv),
    .item       (item),
    .item_valid (in_v)
  );

  clcd_core #(
    .DELAY_WIDTH (DELAY_WIDTH)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .item   (item),
    .cfg    (cfg),
    .result (result),
    .status (st)
  );

  clcd_out_reg u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .result   (result),
    .can_load (can_load),
    .out_chan (out_chan)
  );

`ifndef NO_ASSERTIONS
  a_adv_loads: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_chan.valid)
    else $error("processed tick did not reach the result register");

  a_item_held: assert property (@(posedge clk) disable iff (!rst_n)
    (in_v && !adv) |=> in_v)
    else $error("pending tick dropped from the input register");

  a_no_adv_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && !out_chan.ready) |-> !adv)
    else $error("sequencer advanced while the result register was stalled");

  a_idle_delay: assert property (@(posedge clk) disable iff (!rst_n)
    st.idle == st.delay_zero)
    else $error("phase countdown inconsistent with idle state");
`endif

endmodule

// ----- design/clcd_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// clcd_cfg_regs: configuration registers
// Timing and initialization command registers behind a plain write port.
// ----------------------------------------------------------------------------
module clcd_cfg_regs
  import clcd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output cfg_t        cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.phase_ticks      <= PHASE_TICKS_RST;
      cfg_r.power_on_wait    <= POWER_ON_WAIT_RST;
      cfg_r.first_init_wait  <= FIRST_INIT_WAIT_RST;
      cfg_r.second_init_wait <= SECOND_INIT_WAIT_RST;
      cfg_r.function_set_cmd <= FUNCTION_SET_RST;
      cfg_r.display_cmd      <= DISPLAY_CMD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PHASE_TICKS:      cfg_r.phase_ticks      <= cfg_data[7:0];
        CFG_POWER_ON_WAIT:    cfg_r.power_on_wait    <= cfg_data;
        CFG_FIRST_INIT_WAIT:  cfg_r.first_init_wait  <= cfg_data;
        CFG_SECOND_INIT_WAIT: cfg_r.second_init_wait <= cfg_data;
        CFG_FUNCTION_SET_CMD: cfg_r.function_set_cmd <= cfg_data[7:0];
        CFG_DISPLAY_CMD:      cfg_r.display_cmd      <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- design/clcd_in_reg.sv -----
// ----------------------------------------------------------------------------
// clcd_in_reg: input register
// Captures one tick item and holds it until the sequencer consumes it.
// ----------------------------------------------------------------------------
module clcd_in_reg
  import clcd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  clcd_in_if.sink    in_chan,
  input  logic       adv,
  output item_t      item,
  output logic       item_valid
);

  logic  valid_r;
  item_t item_r;

  assign in_chan.ready = !valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_chan.valid && in_chan.ready) begin
      valid_r <= 1'b1;
    end else if (adv) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      item_r.operation    <= in_chan.operation;
      item_r.command_byte <= in_chan.command_byte;
      item_r.bus_in       <= in_chan.bus_in;
    end
  end

  assign item       = item_r;
  assign item_valid = valid_r;

endmodule

// ----- design/clcd_core.sv -----
// ----------------------------------------------------------------------------
// clcd_core: pin phase sequencer
// Holds the sequencer state and works out one tick: command start, pin
// pattern of the current phase, and the phase countdown and transitions.
// ----------------------------------------------------------------------------
module clcd_core
  import clcd_pkg::*;
#(
  parameter int DELAY_WIDTH = DELAY_WIDTH_DEF
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    adv,
  input  item_t   item,
  input  cfg_t    cfg,
  output result_t result,
  output status_t status
);

  localparam logic [31:0] DelayMax = 32'hFFFF_FFFF >> (32 - DELAY_WIDTH);

  function automatic logic [DELAY_WIDTH-1:0] sat_ticks(input logic [15:0] t);
    logic [31:0] w;
    w = {16'd0, t};
    if (w == 32'd0) w = 32'd1;
    if (w > DelayMax) w = DelayMax;
    return w[DELAY_WIDTH-1:0];
  endfunction

  phase_t                 ph_r, ph_a, ph_nxt;
  logic [DELAY_WIDTH-1:0] delay_r, dly_a, delay_nxt;
  logic [7:0]             pend_r, pend_a, pend_nxt;
  logic [2:0]             op_r, op_a;
  logic [3:0]             step_r, step_a, step_nxt;
  logic [3:0]             hold_r, hold_a, hold_nxt;
  logic                   busy_r, busy_nxt;
  logic [7:0]             rhold_r, rhold_nxt;
  logic                   ready, rej, valid;
  logic                   rs, rw, en, drive;
  logic [3:0]             data;
  logic [DELAY_WIDTH-1:0] pin_ticks;
  igo_t                   ig_a, ig_f;

  assign pin_ticks = sat_ticks({8'd0, cfg.phase_ticks});
  assign ig_a      = init_go(4'd0, cfg);
  assign ig_f      = init_go(step_a, cfg);
  assign ready     = (ph_r == PH_IDLE);

  // Command start: an operation taken while idle enters its first phase
  // on this same tick.
  always_comb begin
    ph_a   = ph_r;
    dly_a  = delay_r;
    pend_a = pend_r;
    op_a   = op_r;
    step_a = step_r;
    hold_a = hold_r;
    rej    = 1'b0;
    if (item.operation >= OP_WR_INSTR && item.operation <= OP_INIT) begin
      if (!ready) begin
        rej = 1'b1;
      end else begin
        op_a   = item.operation;
        pend_a = item.command_byte;
        if (item.operation == OP_RD_BUSY) begin
          ph_a  = PH_RD0;
          dly_a = pin_ticks;
        end else if (item.operation == OP_INIT) begin
          ph_a   = ig_a.ph;
          step_a = ig_a.step;
          dly_a  = (ig_a.ph == PH_IDLE) ? '0 : sat_ticks(ig_a.ticks);
          if (ig_a.hold_we) hold_a = ig_a.hold;
          if (ig_a.pend_we) pend_a = ig_a.pend;
        end else begin
          ph_a  = PH_POLL0;
          dly_a = pin_ticks;
        end
      end
    end
  end

  // Pin pattern of the phase in force on this tick.
  always_comb begin
    rs    = 1'b0;
    rw    = 1'b0;
    en    = 1'b0;
    data  = 4'd0;
    drive = 1'b0;
    if (ph_a >= PH_POLL0 && ph_a <= PH_POLL4) begin
      rw = 1'b1;
      en = (ph_a == PH_POLL1) || (ph_a == PH_POLL3);
    end else if (ph_a >= PH_WR0 && ph_a <= PH_WR5) begin
      rs    = (op_a == OP_WR_DATA);
      en    = (ph_a == PH_WR1) || (ph_a == PH_WR4);
      data  = (ph_a < PH_WR3) ? pend_a[7:4] : pend_a[3:0];
      drive = 1'b1;
    end else if (ph_a >= PH_RD0 && ph_a <= PH_RD5) begin
      rs = (op_a == OP_RD_DATA);
      rw = 1'b1;
      en = (ph_a == PH_RD1) || (ph_a == PH_RD4);
    end else if (ph_a >= PH_NB0 && ph_a <= PH_NB2) begin
      en    = (ph_a == PH_NB1);
      data  = hold_a;
      drive = 1'b1;
    end
  end

  // Countdown, sampling on the last tick of a phase, and the next phase.
  always_comb begin
    ph_nxt    = ph_a;
    delay_nxt = dly_a;
    step_nxt  = step_a;
    hold_nxt  = hold_a;
    pend_nxt  = pend_a;
    busy_nxt  = busy_r;
    rhold_nxt = rhold_r;
    valid     = 1'b0;
    if (ph_a != PH_IDLE) begin
      if (dly_a > DELAY_WIDTH'(1)) begin
        delay_nxt = dly_a - DELAY_WIDTH'(1);
      end else begin
        if (ph_a == PH_POLL1) busy_nxt = item.bus_in[3];
        if (ph_a == PH_RD1) hold_nxt = item.bus_in;
        if (ph_a == PH_RD4) rhold_nxt = {hold_a, item.bus_in};
        priority if (ph_a == PH_POLL4) begin
          delay_nxt = pin_ticks;
          if (busy_nxt) ph_nxt = PH_POLL0;
          else if (op_a == OP_RD_DATA) ph_nxt = PH_RD0;
          else ph_nxt = PH_WR0;
        end else if (ph_a == PH_RD5) begin
          ph_nxt    = PH_IDLE;
          delay_nxt = '0;
          valid     = 1'b1;
        end else if (ph_a == PH_WAIT || ph_a == PH_NB2 ||
                     (ph_a == PH_WR5 && op_a == OP_INIT)) begin
          ph_nxt    = ig_f.ph;
          step_nxt  = ig_f.step;
          delay_nxt = (ig_f.ph == PH_IDLE) ? '0 : sat_ticks(ig_f.ticks);
          if (ig_f.hold_we) hold_nxt = ig_f.hold;
          if (ig_f.pend_we) pend_nxt = ig_f.pend;
        end else if ((ph_a >= PH_POLL0 && ph_a < PH_WR5) ||
                     (ph_a >= PH_WR0 && ph_a < PH_RD5 && ph_a != PH_WR5) ||
                     (ph_a >= PH_NB0 && ph_a < PH_NB2)) begin
          ph_nxt    = phase_t'(ph_a + 5'd1);
          delay_nxt = pin_ticks;
        end else begin
          ph_nxt    = PH_IDLE;
          delay_nxt = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r    <= PH_IDLE;
      delay_r <= '0;
      pend_r  <= 8'd0;
      op_r    <= OP_TICK;
      step_r  <= 4'd0;
      hold_r  <= 4'd0;
      busy_r  <= 1'b0;
      rhold_r <= 8'd0;
    end else if (adv) begin
      ph_r    <= ph_nxt;
      delay_r <= delay_nxt;
      pend_r  <= pend_nxt;
      op_r    <= op_a;
      step_r  <= step_nxt;
      hold_r  <= hold_nxt;
      busy_r  <= busy_nxt;
      rhold_r <= rhold_nxt;
    end
  end

  assign result.pin_rs     = rs;
  assign result.pin_rw     = rw;
  assign result.pin_enable = en;
  assign result.pin_data   = data;
  assign result.data_drive = drive;
  assign result.ready_res  = ready;
  assign result.read_valid = valid;
  assign result.read_byte  = rhold_nxt;
  assign result.rejected   = rej;

  assign status.idle       = (ph_r == PH_IDLE);
  assign status.delay_zero = (delay_r == '0);

endmodule

// ----- design/clcd_out_reg.sv -----
// ----------------------------------------------------------------------------
// clcd_out_reg: result register
// Holds one tick's pin result until the receiver takes it.
// ----------------------------------------------------------------------------
module clcd_out_reg
  import clcd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      adv,
  input  result_t   result,
  output logic      can_load,
  clcd_out_if.source out_chan
);

  logic    valid_r;
  result_t res_r;

  assign can_load = !valid_r || out_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= result;
    end
  end

  assign out_chan.valid      = valid_r;
  assign out_chan.pin_rs     = res_r.pin_rs;
  assign out_chan.pin_rw     = res_r.pin_rw;
  assign out_chan.pin_enable = res_r.pin_enable;
  assign out_chan.pin_data   = res_r.pin_data;
  assign out_chan.data_drive = res_r.data_drive;
  assign out_chan.ready_res  = res_r.ready_res;
  assign out_chan.read_valid = res_r.read_valid;
  assign out_chan.read_byte  = res_r.read_byte;
  assign out_chan.rejected   = res_r.rejected;

endmodule

// ----- tb/sv/char_lcd_4bit_bus_controller_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_lcd_4bit_bus_controller_tb: self-checking bench for the LCD bus sequencer
// Every tick transfer accepted on in_chan is run through a local model of the
// phase sequencer, and every result transfer on out_chan is compared with the
// oldest predicted pin pattern. A short stimulus table comes first, then
// random command traffic under several register settings and idling mixes.
// ----------------------------------------------------------------------------
module char_lcd_4bit_bus_controller_tb;
  import clcd_pkg::*;

  localparam int          CYCLE_LIMIT = 1_000_000;
  localparam int unsigned DELAY_MAX   = (1 << DELAY_WIDTH_DEF) - 1;
  localparam logic [2:0]  OP_UNDEF_LO = 3'd6;
  localparam logic [2:0]  OP_UNDEF_HI = 3'd7;

  typedef enum {SRC_TABLE, SRC_RANDOM, SRC_DRAIN} src_mode_t;

  typedef struct {
    item_t   it;
    bit      known;
    result_t res;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  clcd_in_if  in_ch ();
  clcd_out_if out_ch ();

  char_lcd_4bit_bus_controller uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_ch),
    .out_chan (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // Sequencer model state and register shadow.
  cfg_t        regs;
  phase_t      seq_phase;
  int unsigned seq_delay;
  logic [7:0]  seq_pend;
  logic [2:0]  seq_op;
  logic [3:0]  seq_step;
  logic [3:0]  seq_hold;
  logic        seq_busy;
  logic [7:0]  seq_rdbyte;

  result_t     pending_pins[$];
  stim_row_t   stim_rows[$];
  item_t       cur_item;
  bit          cur_known;
  result_t     cur_res;
  bit          init_first;
  int          send_idle_pct;
  int          recv_stall_pct;
  int          mismatches;
  int          cycle_count;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic void load_phase(phase_t ph, int unsigned ticks);
    if (ticks == 0) ticks = 1;
    if (ticks > DELAY_MAX) ticks = DELAY_MAX;
    seq_phase = ph;
    seq_delay = ticks;
  endfunction

  // Walks the power-on steps; a step whose wait is zero falls straight through.
  function automatic void run_init();
    bit          done;
    int unsigned s;
    done = 1'b0;
    while (!done) begin
      s    = seq_step;
      done = 1'b1;
      if (s < 11) seq_step = 4'(s + 1);
      case (s)
        0: if (regs.power_on_wait != 0) load_phase(PH_WAIT, regs.power_on_wait);
           else done = 1'b0;
        2: if (regs.first_init_wait != 0) load_phase(PH_WAIT, regs.first_init_wait);
           else done = 1'b0;
        4: if (regs.second_init_wait != 0) load_phase(PH_WAIT, regs.second_init_wait);
           else done = 1'b0;
        1, 3, 5: begin
          seq_hold = INIT_NIBBLE;
          load_phase(PH_NB0, regs.phase_ticks);
        end
        6: begin
          seq_hold = FOUR_BIT_NIBBLE;
          load_phase(PH_NB0, regs.phase_ticks);
        end
        7, 8, 9, 10: begin
          seq_pend = (s == 7) ? regs.function_set_cmd :
                     (s == 8) ? CMD_CLEAR :
                     (s == 9) ? CMD_HOME : regs.display_cmd;
          load_phase(PH_POLL0, regs.phase_ticks);
        end
        default: begin
          seq_phase = PH_IDLE;
          seq_delay = 0;
        end
      endcase
    end
  endfunction

  // One tick of the sequencer: takes the command, decodes the pins of the
  // current phase, then counts the phase down.
  function automatic result_t next_pins(item_t it);
    result_t r;
    phase_t  ph;
    logic    idle_now;
    r        = '0;
    idle_now = (seq_phase == PH_IDLE);
    if (it.operation >= OP_WR_INSTR && it.operation <= OP_INIT) begin
      if (!idle_now) begin
        r.rejected = 1'b1;
      end else begin
        seq_op   = it.operation;
        seq_pend = it.command_byte;
        if (it.operation == OP_RD_BUSY) begin
          load_phase(PH_RD0, regs.phase_ticks);
        end else if (it.operation == OP_INIT) begin
          seq_step = 4'd0;
          run_init();
        end else begin
          load_phase(PH_POLL0, regs.phase_ticks);
        end
      end
    end

    ph = seq_phase;
    if (ph >= PH_POLL0 && ph <= PH_POLL4) begin
      r.pin_rw     = 1'b1;
      r.pin_enable = (ph == PH_POLL1 || ph == PH_POLL3);
    end else if (ph >= PH_WR0 && ph <= PH_WR5) begin
      r.pin_rs     = (seq_op == OP_WR_DATA);
      r.pin_enable = (ph == PH_WR1 || ph == PH_WR4);
      r.pin_data   = (ph < PH_WR3) ? seq_pend[7:4] : seq_pend[3:0];
      r.data_drive = 1'b1;
    end else if (ph >= PH_RD0 && ph <= PH_RD5) begin
      r.pin_rs     = (seq_op == OP_RD_DATA);
      r.pin_rw     = 1'b1;
      r.pin_enable = (ph == PH_RD1 || ph == PH_RD4);
    end else if (ph >= PH_NB0 && ph <= PH_NB2) begin
      r.pin_enable = (ph == PH_NB1);
      r.pin_data   = seq_hold;
      r.data_drive = 1'b1;
    end

    if (ph != PH_IDLE) begin
      if (seq_delay > 1) begin
        seq_delay--;
      end else begin
        // The bus is sampled on the last tick of an enable-high phase.
        if (ph == PH_POLL1) seq_busy = it.bus_in[3];
        if (ph == PH_RD1) seq_hold = it.bus_in;
        if (ph == PH_RD4) seq_rdbyte = {seq_hold, it.bus_in};
        case (ph)
          PH_POLL4: begin
            if (seq_busy) load_phase(PH_POLL0, regs.phase_ticks);
            else if (seq_op == OP_RD_DATA) load_phase(PH_RD0, regs.phase_ticks);
            else load_phase(PH_WR0, regs.phase_ticks);
          end
          PH_WR5: begin
            if (seq_op == OP_INIT) begin
              run_init();
            end else begin
              seq_phase = PH_IDLE;
              seq_delay = 0;
            end
          end
          PH_RD5: begin
            seq_phase    = PH_IDLE;
            seq_delay    = 0;
            r.read_valid = 1'b1;
          end
          PH_WAIT, PH_NB2: run_init();
          default: load_phase(phase_t'(ph + 1), regs.phase_ticks);
        endcase
      end
    end
    r.ready_res = idle_now;
    r.read_byte = seq_rdbyte;
    return r;
  endfunction

  function automatic result_t pins(logic rs, logic rw, logic en, logic [3:0] data,
                                   logic drv, logic rdy, logic rv, logic [7:0] rbyte,
                                   logic rej);
    result_t r;
    r = {rs, rw, en, data, drv, rdy, rv, rbyte, rej};
    return r;
  endfunction

  function automatic string show(result_t r);
    return $sformatf("rs=%b rw=%b en=%b data=%h drv=%b rdy=%b rv=%b byte=%h rej=%b",
                     r.pin_rs, r.pin_rw, r.pin_enable, r.pin_data, r.data_drive,
                     r.ready_res, r.read_valid, r.read_byte, r.rejected);
  endfunction

  function automatic void add_row(logic [2:0] op, logic [7:0] cmd, logic [3:0] bus,
                                  bit known = 1'b0, result_t res = '0);
    stim_row_t row;
    row.it.operation    = op;
    row.it.command_byte = cmd;
    row.it.bus_in       = bus;
    row.known           = known;
    row.res             = res;
    stim_rows.push_back(row);
  endfunction

  // Result side: random back-pressure and the compare against the oldest
  // predicted pin pattern.
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (out_ch.valid && out_ch.ready) begin
      got = {out_ch.pin_rs, out_ch.pin_rw, out_ch.pin_enable, out_ch.pin_data,
             out_ch.data_drive, out_ch.ready_res, out_ch.read_valid,
             out_ch.read_byte, out_ch.rejected};
      if (pending_pins.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transfer: %s", show(got));
      end else begin
        want = pending_pins.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("pin mismatch at cycle %0d\n  expected %s\n  actual   %s",
                     cycle_count, show(want), show(got));
        end
      end
    end
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Drives tick transfers until the mode's stop condition holds. The next item
  // is chosen after the model has taken the one just accepted.
  task automatic run_ticks(input src_mode_t mode, input int count);
    int      sent;
    int      roll;
    bit      took;
    bit      done;
    bit      stop;
    item_t   nxt;
    result_t predicted;
    sent = 0;
    done = 1'b0;
    while (!done) begin
      @(posedge clk);
      took = in_ch.valid && in_ch.ready;
      if (took) begin
        predicted = next_pins(cur_item);
        pending_pins.push_back(cur_known ? cur_res : predicted);
        sent++;
      end
      if (!in_ch.valid || took) begin
        case (mode)
          SRC_TABLE:  stop = (sent >= stim_rows.size());
          SRC_RANDOM: stop = (sent >= count);
          default:    stop = (seq_phase == PH_IDLE);
        endcase
        if (stop) begin
          in_ch.valid <= 1'b0;
          done = 1'b1;
        end else if ($urandom_range(99) < send_idle_pct) begin
          in_ch.valid <= 1'b0;
        end else begin
          cur_known        = 1'b0;
          nxt.command_byte = 8'($urandom_range(255));
          nxt.bus_in       = 4'($urandom_range(15));
          if (mode == SRC_TABLE) begin
            nxt       = stim_rows[sent].it;
            cur_known = stim_rows[sent].known;
            cur_res   = stim_rows[sent].res;
          end else if (mode == SRC_DRAIN) begin
            nxt.operation = OP_TICK;
          end else if (seq_phase == PH_IDLE) begin
            roll = $urandom_range(99);
            if (init_first) begin
              nxt.operation = OP_INIT;
              init_first    = 1'b0;
            end else if (roll < 30) nxt.operation = OP_WR_INSTR;
            else if (roll < 60) nxt.operation = OP_WR_DATA;
            else if (roll < 72) nxt.operation = OP_RD_BUSY;
            else if (roll < 90) nxt.operation = OP_RD_DATA;
            else if (roll < 95) nxt.operation = OP_INIT;
            else if (roll < 97) nxt.operation = OP_TICK;
            else nxt.operation = $urandom_range(1) ? OP_UNDEF_HI : OP_UNDEF_LO;
          end else begin
            // While busy: mostly plain ticks, some commands that must be refused.
            nxt.operation = ($urandom_range(99) < 88) ? OP_TICK : 3'($urandom_range(7));
          end
          cur_item           = nxt;
          in_ch.valid        <= 1'b1;
          in_ch.operation    <= nxt.operation;
          in_ch.command_byte <= nxt.command_byte;
          in_ch.bus_in       <= nxt.bus_in;
        end
      end
    end
  endtask

  task automatic settle();
    while (pending_pins.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [15:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      CFG_PHASE_TICKS:      regs.phase_ticks      = val[7:0];
      CFG_POWER_ON_WAIT:    regs.power_on_wait    = val;
      CFG_FIRST_INIT_WAIT:  regs.first_init_wait  = val;
      CFG_SECOND_INIT_WAIT: regs.second_init_wait = val;
      CFG_FUNCTION_SET_CMD: regs.function_set_cmd = val[7:0];
      CFG_DISPLAY_CMD:      regs.display_cmd      = val[7:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [7:0] ticks, input logic [15:0] pow,
                            input logic [15:0] first, input logic [15:0] second,
                            input logic [7:0] fset, input logic [7:0] disp);
    settle();
    write_reg(CFG_PHASE_TICKS, {8'd0, ticks});
    write_reg(CFG_POWER_ON_WAIT, pow);
    write_reg(CFG_FIRST_INIT_WAIT, first);
    write_reg(CFG_SECOND_INIT_WAIT, second);
    write_reg(CFG_FUNCTION_SET_CMD, {8'd0, fset});
    write_reg(CFG_DISPLAY_CMD, {8'd0, disp});
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("char_lcd_4bit_bus_controller_tb: done, errors");
    $finish;
  end

  initial begin
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = '0;
    cfg_data           = '0;
    in_ch.valid        = 1'b0;
    in_ch.operation    = OP_TICK;
    in_ch.command_byte = '0;
    in_ch.bus_in       = '0;
    send_idle_pct      = 0;
    recv_stall_pct     = 0;
    mismatches         = 0;
    init_first         = 1'b0;
    cur_known          = 1'b0;
    cur_item           = '0;
    cur_res            = '0;

    regs.phase_ticks      = PHASE_TICKS_RST;
    regs.power_on_wait    = POWER_ON_WAIT_RST;
    regs.first_init_wait  = FIRST_INIT_WAIT_RST;
    regs.second_init_wait = SECOND_INIT_WAIT_RST;
    regs.function_set_cmd = FUNCTION_SET_RST;
    regs.display_cmd      = DISPLAY_CMD_RST;
    seq_phase  = PH_IDLE;
    seq_delay  = 0;
    seq_pend   = '0;
    seq_op     = OP_TICK;
    seq_step   = '0;
    seq_hold   = '0;
    seq_busy   = 1'b0;
    seq_rdbyte = '0;

    // Idle after reset, then the two undefined codes, which are plain ticks.
    add_row(OP_TICK, 8'h00, 4'h0, 1'b1, pins(0, 0, 0, 4'h0, 0, 1, 0, 8'h00, 0));
    add_row(OP_UNDEF_LO, 8'hFF, 4'hF, 1'b1, pins(0, 0, 0, 4'h0, 0, 1, 0, 8'h00, 0));
    add_row(OP_UNDEF_HI, 8'h00, 4'h0, 1'b1, pins(0, 0, 0, 4'h0, 0, 1, 0, 8'h00, 0));
    // Address/busy read of 0xF0, with a write refused on its enable tick.
    add_row(OP_RD_BUSY, 8'h5A, 4'hF);
    add_row(OP_WR_INSTR, 8'hA5, 4'hF, 1'b1, pins(0, 1, 1, 4'h0, 0, 0, 0, 8'h00, 1));
    add_row(OP_TICK, 8'h00, 4'hF);
    add_row(OP_TICK, 8'h00, 4'hF);
    add_row(OP_TICK, 8'h00, 4'h0);
    add_row(OP_TICK, 8'h00, 4'h0, 1'b1, pins(0, 1, 0, 4'h0, 0, 0, 1, 8'hF0, 0));
    // Data read: the first poll sees busy and repeats, the second reads 0xA5.
    add_row(OP_RD_DATA, 8'hFF, 4'h0);
    add_row(OP_TICK, 8'h00, 4'h8);
    add_row(OP_TICK, 8'h00, 4'h0);
    add_row(OP_TICK, 8'h00, 4'h0);
    add_row(OP_TICK, 8'h00, 4'h0);
    add_row(OP_WR_DATA, 8'h3C, 4'h0);
    add_row(OP_TICK, 8'h00, 4'h0);
    add_row(OP_TICK, 8'h00, 4'hF);
    add_row(OP_TICK, 8'h00, 4'hF);
    add_row(OP_TICK, 8'h00, 4'hF);
    add_row(OP_TICK, 8'h00, 4'h0);
    add_row(OP_TICK, 8'h00, 4'hA);
    add_row(OP_TICK, 8'h00, 4'h0);
    add_row(OP_TICK, 8'h00, 4'h0);
    add_row(OP_TICK, 8'h00, 4'h5);
    add_row(OP_TICK, 8'h00, 4'h0, 1'b1, pins(1, 1, 0, 4'h0, 0, 0, 1, 8'hA5, 0));
    // Instruction write of all ones, then an init that comes too early.
    add_row(OP_WR_INSTR, 8'hFF, 4'h0);
    add_row(OP_INIT, 8'h00, 4'h7);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    run_ticks(SRC_TABLE, 0);
    run_ticks(SRC_DRAIN, 0);

    // Fastest timing, all init waits skipped.
    set_config(8'd1, 16'd0, 16'd0, 16'd0, FUNCTION_SET_RST, DISPLAY_CMD_RST);
    init_first = 1'b1;
    run_ticks(SRC_RANDOM, 330);

    send_idle_pct = 88;
    set_config(8'd2, 16'd3, 16'd2, 16'd1, 8'($urandom_range(255)),
               8'($urandom_range(255)));
    init_first = 1'b1;
    run_ticks(SRC_RANDOM, 330);

    // A phase length of zero behaves as one tick.
    send_idle_pct  = 0;
    recv_stall_pct = 88;
    set_config(8'd0, 16'd1, 16'd0, 16'd5, 8'($urandom_range(255)),
               8'($urandom_range(255)));
    run_ticks(SRC_RANDOM, 330);

    send_idle_pct  = 38;
    recv_stall_pct = 38;
    set_config(8'd3, 16'($urandom_range(6)), 16'($urandom_range(6)),
               16'($urandom_range(6)), 8'hFF, 8'h00);
    init_first = 1'b1;
    run_ticks(SRC_RANDOM, 340);

    // Longest phases.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    set_config(8'd255, 16'd0, 16'd0, 16'd0, 8'($urandom_range(255)),
               8'($urandom_range(255)));
    init_first = 1'b1;
    run_ticks(SRC_RANDOM, 60);

    // Longest power-on wait, loaded and counted down for a while.
    set_config(8'd1, 16'hFFFF, 16'd0, 16'd1, 8'($urandom_range(255)),
               8'($urandom_range(255)));
    init_first = 1'b1;
    run_ticks(SRC_RANDOM, 40);

    settle();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("char_lcd_4bit_bus_controller_tb: done, clean");
    end else begin
      $display("char_lcd_4bit_bus_controller_tb: done, errors");
    end
    $finish;
  end

endmodule
